[design/coo_sparse_dense_matmul_core_assert.svh]
// Assertion macros for the sparse-times-dense matmul core
`ifndef COO_SPARSE_DENSE_MATMUL_CORE_ASSERT_SVH
`define COO_SPARSE_DENSE_MATMUL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset
`define CSDM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csdm assertion failed");
// Next-cycle implication checked outside reset
`define CSDM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csdm assertion failed");
`else
`define CSDM_ASSERT_IMP(lbl, ante, cons)
`define CSDM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/csdm_pkg.sv]
// Package: types, constants and codes of the sparse-times-dense matmul core
`default_nettype none
package csdm_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_INNER = 64;
    localparam int MAX_COLS  = 16;

    localparam int VAL_W   = 32;
    localparam int IDX_W   = 6;
    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int INN_AW  = $clog2(MAX_INNER);
    localparam int POS_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NCOL_W  = 5;
    localparam int DRAIN   = MAX_COLS + 2;
    localparam int CNT_W   = $clog2(DRAIN + 1);
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = PROD_W - 16 + 1;

    typedef enum logic [1:0] {
        KIND_LOAD_B = 2'd0,
        KIND_LOAD_C = 2'd1,
        KIND_ACC    = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [VAL_W-1:0]  value;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic              saturated;
    } out_t;

    // Transaction token walking down the cell chain
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  pos;
    } token_t;

    // Per-cell status towards the top level
    typedef struct packed {
        logic              hit;
        logic [VAL_W-1:0]  data;
        logic              sat;
    } cell_evt_t;

endpackage
`default_nettype wire

[design/csdm_cell.sv]
// One column cell: holds a column of B and of C and its own multiply-accumulate
`default_nettype none
module csdm_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire csdm_pkg::token_t               tok_i,
    input  wire logic [csdm_pkg::NCOL_W-1:0]    ncols_i,
    output csdm_pkg::token_t                    tok_o,
    output csdm_pkg::cell_evt_t                 evt_o
);

    logic [csdm_pkg::VAL_W-1:0] b_mem [csdm_pkg::MAX_INNER];
    logic [csdm_pkg::VAL_W-1:0] c_mem [csdm_pkg::MAX_ROWS];

    csdm_pkg::token_t tok_reg;

    logic col_match, mac_go, b_we, c_load, rd_go;

    logic                              s1_mac_reg, s1_rd_reg;
    logic [csdm_pkg::ROW_AW-1:0]       s1_row_reg;
    logic signed [csdm_pkg::VAL_W-1:0] s1_val_reg;
    logic signed [csdm_pkg::VAL_W-1:0] b_rd_reg;
    logic signed [csdm_pkg::VAL_W-1:0] c_rd_reg;

    logic                               s2_mac_reg;
    logic [csdm_pkg::ROW_AW-1:0]        s2_row_reg;
    logic signed [csdm_pkg::VAL_W-1:0]  s2_c_reg;
    logic signed [csdm_pkg::PROD_W-1:0] s2_prod_reg;

    logic signed [csdm_pkg::SUM_W-1:0] sum;
    logic                              sat_hi, sat_lo;
    logic signed [csdm_pkg::VAL_W-1:0] acc_val;

    logic                              c_we;
    logic [csdm_pkg::ROW_AW-1:0]       c_waddr;
    logic [csdm_pkg::VAL_W-1:0]        c_wdata;

    // Decode the token against this cell's column position
    always_comb begin
        col_match = (tok_i.col == csdm_pkg::IDX_W'(tok_i.pos));
        mac_go    = tok_i.valid && (tok_i.kind == csdm_pkg::KIND_ACC)
                    && (csdm_pkg::NCOL_W'(tok_i.pos) < ncols_i);
        b_we      = tok_i.valid && (tok_i.kind == csdm_pkg::KIND_LOAD_B) && col_match;
        c_load    = tok_i.valid && (tok_i.kind == csdm_pkg::KIND_LOAD_C) && col_match;
        rd_go     = tok_i.valid && (tok_i.kind == csdm_pkg::KIND_READ) && col_match;
    end

    // Hand the token on to the next cell through a register, position advanced by one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_i.valid;
        end
        tok_reg.kind  <= tok_i.kind;
        tok_reg.row   <= tok_i.row;
        tok_reg.col   <= tok_i.col;
        tok_reg.value <= tok_i.value;
        tok_reg.pos   <= tok_i.pos + csdm_pkg::POS_W'(1);
    end
    assign tok_o = tok_reg;

    // B column store
    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[tok_i.row[csdm_pkg::INN_AW-1:0]] <= tok_i.value;
        end
        b_rd_reg <= b_mem[tok_i.col[csdm_pkg::INN_AW-1:0]];
    end

    // C column store: load write on entry, accumulate write from stage 2
    always_comb begin
        c_we    = c_load || s2_mac_reg;
        c_waddr = s2_mac_reg ? s2_row_reg : tok_i.row[csdm_pkg::ROW_AW-1:0];
        c_wdata = s2_mac_reg ? acc_val : tok_i.value;
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            c_mem[c_waddr] <= c_wdata;
        end
        c_rd_reg <= c_mem[tok_i.row[csdm_pkg::ROW_AW-1:0]];
    end

    // Stage 1: operands read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_mac_reg <= 1'b0;
            s1_rd_reg  <= 1'b0;
        end else begin
            s1_mac_reg <= mac_go;
            s1_rd_reg  <= rd_go;
        end
        s1_row_reg <= tok_i.row[csdm_pkg::ROW_AW-1:0];
        s1_val_reg <= tok_i.value;
    end

    // Stage 2: full product registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_mac_reg <= 1'b0;
        end else begin
            s2_mac_reg <= s1_mac_reg;
        end
        s2_row_reg  <= s1_row_reg;
        s2_c_reg    <= c_rd_reg;
        s2_prod_reg <= s1_val_reg * b_rd_reg;
    end

    // Floor to Q16.16, add, saturate to 32 bits
    always_comb begin
        sum    = csdm_pkg::SUM_W'(s2_c_reg)
                 + csdm_pkg::SUM_W'($signed(s2_prod_reg[csdm_pkg::PROD_W-1:16]));
        sat_hi = (sum > csdm_pkg::SUM_W'(32'sh7fff_ffff));
        sat_lo = (sum < -csdm_pkg::SUM_W'(33'sh0_8000_0000));
        priority if (sat_hi) begin
            acc_val = 32'sh7fff_ffff;
        end else if (sat_lo) begin
            acc_val = 32'sh8000_0000;
        end else begin
            acc_val = sum[csdm_pkg::VAL_W-1:0];
        end
    end

    assign evt_o.hit  = s1_rd_reg;
    assign evt_o.data = c_rd_reg;
    assign evt_o.sat  = s2_mac_reg && (sat_hi || sat_lo);

endmodule
`default_nettype wire

[design/coo_sparse_dense_matmul_core.sv]
// Top level: cell chain, transaction sequencer and result register
//
//  channel  | ports                      | direction
//  ---------+----------------------------+----------
//  input    | s_valid, s_ready, s_data   | in
//  result   | m_valid, m_ready, m_data   | out (read transactions only)
//  config   | cfg_we, cfg_wdata          | in
//
// s_ready drops after each acceptance and comes back only once the transaction
// has walked the column cells, passed the last cell's multiply-add pipeline
// and been closed out, so the core takes no new transaction before then.
// Reset is synchronous on aresetn; B and C stores are not cleared.
// A read result sits in the output register; if it is still held when the
// next read finishes, the core waits for the slot before taking more input.
`default_nettype none
`include "coo_sparse_dense_matmul_core_assert.svh"
module coo_sparse_dense_matmul_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire csdm_pkg::in_t                 s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output csdm_pkg::out_t                     m_data,
    input  wire logic                          cfg_we,
    input  wire logic [csdm_pkg::NCOL_W-1:0]   cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [csdm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [csdm_pkg::NCOL_W-1:0] active_reg;
    logic [csdm_pkg::NCOL_W-1:0] ncols;
    logic                        is_read_reg;
    logic                        overflow_reg;
    logic [csdm_pkg::VAL_W-1:0]  rd_hold_reg;
    logic                        m_valid_reg;
    csdm_pkg::out_t              m_data_reg;

    csdm_pkg::token_t    tok_reg;
    csdm_pkg::token_t    tok_chain [csdm_pkg::MAX_COLS+1];
    csdm_pkg::cell_evt_t evt [csdm_pkg::MAX_COLS];

    logic [csdm_pkg::MAX_COLS-1:0] hit_vec, sat_vec;
    logic [csdm_pkg::VAL_W-1:0]    hit_data;
    logic                          accept, done, slot_free, load_out;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign done      = (state_reg == ST_RUN) && (cnt_reg == csdm_pkg::CNT_W'(csdm_pkg::DRAIN));

    // Column count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= csdm_pkg::NCOL_W'(csdm_pkg::MAX_COLS);
        end else if (cfg_we) begin
            active_reg <= cfg_wdata;
        end
    end
    assign ncols = (active_reg > csdm_pkg::NCOL_W'(csdm_pkg::MAX_COLS))
                   ? csdm_pkg::NCOL_W'(csdm_pkg::MAX_COLS) : active_reg;

    // Inject the accepted transaction at the head of the chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= accept;
        end
        if (accept) begin
            tok_reg.kind  <= csdm_pkg::kind_t'(s_data.kind);
            tok_reg.row   <= s_data.row_index;
            tok_reg.col   <= s_data.col_index;
            tok_reg.value <= s_data.value;
        end
        tok_reg.pos <= '0;
    end
    assign tok_chain[0] = tok_reg;

    // Row of column cells
    for (genvar i = 0; i < csdm_pkg::MAX_COLS; i++) begin : g_cell
        csdm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (tok_chain[i]),
            .ncols_i (ncols),
            .tok_o   (tok_chain[i+1]),
            .evt_o   (evt[i])
        );
    end

    // Gather cell events
    always_comb begin
        hit_data = '0;
        for (int i = 0; i < csdm_pkg::MAX_COLS; i++) begin
            hit_vec[i] = evt[i].hit;
            sat_vec[i] = evt[i].sat;
            hit_data   = hit_data | (evt[i].data & {csdm_pkg::VAL_W{evt[i].hit}});
        end
    end

    // Sticky overflow and read capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overflow_reg <= 1'b0;
        end else if (|sat_vec) begin
            overflow_reg <= 1'b1;
        end
        if (accept) begin
            rd_hold_reg <= '0;
            is_read_reg <= (s_data.kind == csdm_pkg::KIND_READ);
        end else if (|hit_vec) begin
            rd_hold_reg <= hit_data;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + csdm_pkg::CNT_W'(1);
                if (done) begin
                    if (!is_read_reg) begin
                        state_next = ST_IDLE;
                    end else if (slot_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            m_data_reg.read_value <= rd_hold_reg;
            m_data_reg.saturated  <= overflow_reg;
        end
    end
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `CSDM_ASSERT_IMP(a_one_hit, 1'b1, $onehot0(hit_vec))
    `CSDM_ASSERT_NXT(a_ovf_sticky, overflow_reg, overflow_reg)
    `CSDM_ASSERT_NXT(a_accept_runs, accept, state_reg == ST_RUN && tok_reg.valid)
    `CSDM_ASSERT_IMP(a_load_slot, load_out, slot_free && is_read_reg)

endmodule
`default_nettype wire

[tb/tb_coo_sparse_dense_matmul_core.sv]
// Testbench for the sparse-times-dense matmul core: random and directed traffic, scoreboard check
`default_nettype none

class matmul_scoreboard;
    logic signed [31:0] b_elem [0:63][0:15];
    logic signed [31:0] c_elem [0:63][0:15];
    bit                 sat_sticky;
    int                 ncols;
    csdm_pkg::out_t     read_queue[$];
    int                 mismatches;

    function new();
        sat_sticky = 0;
        ncols      = 16;
        mismatches = 0;
    endfunction

    // Apply one accepted input transaction to the shadow matrices
    function void note_input(csdm_pkg::in_t t);
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        csdm_pkg::out_t     r;
        int                 n;
        n = (ncols > 16) ? 16 : ncols;
        unique case (csdm_pkg::kind_t'(t.kind))
            csdm_pkg::KIND_LOAD_B: begin
                if (t.col_index < 16) b_elem[t.row_index][t.col_index[3:0]] = t.value;
            end
            csdm_pkg::KIND_LOAD_C: begin
                if (t.col_index < 16) c_elem[t.row_index][t.col_index[3:0]] = t.value;
            end
            csdm_pkg::KIND_ACC: begin
                for (int c = 0; c < n; c++) begin
                    prod = $signed(t.value) * $signed(b_elem[t.col_index][c]);
                    prod = prod >>> 16;
                    sum  = prod + $signed(c_elem[t.row_index][c]);
                    if (sum > 64'sd2147483647) begin
                        sum = 64'sd2147483647;
                        sat_sticky = 1;
                    end else if (sum < -64'sd2147483648) begin
                        sum = -64'sd2147483648;
                        sat_sticky = 1;
                    end
                    c_elem[t.row_index][c] = sum[31:0];
                end
            end
            default: begin
                r.read_value = (t.col_index < 16) ? c_elem[t.row_index][t.col_index[3:0]] : '0;
                r.saturated  = sat_sticky;
                read_queue.push_back(r);
            end
        endcase
    endfunction

    // Compare one accepted result with the oldest expected read
    function void check_result(csdm_pkg::out_t got);
        csdm_pkg::out_t exp_r;
        if (read_queue.size() == 0) begin
            $error("unexpected result read_value=%h", got.read_value);
            mismatches++;
            return;
        end
        exp_r = read_queue.pop_front();
        if (got.read_value !== exp_r.read_value) begin
            $error("read_value expected %h actual %h", exp_r.read_value, got.read_value);
            mismatches++;
        end
        if (got.saturated !== exp_r.saturated) begin
            $error("saturated expected %0b actual %0b", exp_r.saturated, got.saturated);
            mismatches++;
        end
    endfunction
endclass

module tb_coo_sparse_dense_matmul_core;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    csdm_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    csdm_pkg::out_t m_data;
    logic           cfg_we;
    logic [4:0]     cfg_wdata;

    matmul_scoreboard sb;
    bit               calm;        // no idling on either side
    bit               b_loaded [0:63][0:15];
    bit               c_loaded [0:63][0:15];

    coo_sparse_dense_matmul_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Hard limit on run time
    initial begin
        #8000000;
        $display("[coo_sparse_dense_matmul_core] ERROR");
        $finish;
    end

    // Result side: random back-pressure outside calm phases, checked at rising edge
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            @(negedge aclk);
            m_ready = calm ? 1'b1 : ($urandom_range(99) >= 29);
        end
    end

    // Send one transaction, with a random gap ahead of it outside calm phases
    task automatic send_item(csdm_pkg::in_t t);
        while (!calm && $urandom_range(99) < 29) @(negedge aclk);
        s_valid = 1;
        s_data  = t;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(t);
        if (t.kind == csdm_pkg::KIND_LOAD_B && t.col_index < 16)
            b_loaded[t.row_index][t.col_index[3:0]] = 1;
        if (t.kind == csdm_pkg::KIND_LOAD_C && t.col_index < 16)
            c_loaded[t.row_index][t.col_index[3:0]] = 1;
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic send(logic [1:0] k, logic [5:0] r, logic [5:0] c, logic [31:0] v);
        csdm_pkg::in_t t;
        t.kind = k; t.row_index = r; t.col_index = c; t.value = v;
        send_item(t);
    endtask

    // Wait for all reads, then let a nonzero finish before touching config
    task automatic drain();
        while (sb.read_queue.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_columns(logic [4:0] n);
        drain();
        cfg_we = 1; cfg_wdata = n;
        @(negedge aclk);
        cfg_we = 0;
        sb.ncols = n;
    endtask

    // Random value biased toward extremes and small Q16.16 magnitudes
    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // One to three nonzeros on a row and inner index whose entries are all loaded, then reads of that row
    task automatic random_block();
        logic [5:0] r;
        logic [5:0] k;
        r = 6'($urandom_range(63));
        k = 6'($urandom_range(63));
        for (int c = 0; c < 16; c++) begin
            if (!b_loaded[k][c] || $urandom_range(3) == 0)
                send(csdm_pkg::KIND_LOAD_B, k, 6'(c), rand_value());
            if (!c_loaded[r][c] || $urandom_range(7) == 0)
                send(csdm_pkg::KIND_LOAD_C, r, 6'(c), rand_value());
        end
        repeat ($urandom_range(1, 3)) send(csdm_pkg::KIND_ACC, r, k, rand_value());
        repeat ($urandom_range(1, 3))
            send(csdm_pkg::KIND_READ, r, 6'($urandom_range(15)), 32'd0);
    endtask

    initial begin
        sb        = new();
        aresetn   = 0;
        s_valid   = 0;
        s_data    = '0;
        cfg_we    = 0;
        cfg_wdata = 5'd16;
        calm      = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: full row 0 and inner row 63, extremes, out-of-range items
        for (int c = 0; c < 16; c++) begin
            send(csdm_pkg::KIND_LOAD_B, 6'd63, 6'(c), 32'h7FFF_FFFF);
            send(csdm_pkg::KIND_LOAD_C, 6'd0, 6'(c), (c < 8) ? 32'h7FFF_FFFF : 32'h8000_0000);
        end
        send(csdm_pkg::KIND_LOAD_B, 6'd5, 6'd63, 32'h1234_5678);  // ignored load
        send(csdm_pkg::KIND_LOAD_C, 6'd63, 6'd16, 32'h1);         // ignored load
        send(csdm_pkg::KIND_READ, 6'd0, 6'd0, 32'd0);
        send(csdm_pkg::KIND_READ, 6'd63, 6'd63, 32'hFFFF_FFFF);   // out of range read
        send(csdm_pkg::KIND_ACC, 6'd0, 6'd63, 32'h7FFF_FFFF);     // saturates upward
        send(csdm_pkg::KIND_READ, 6'd0, 6'd0, 32'd0);
        send(csdm_pkg::KIND_ACC, 6'd0, 6'd63, 32'h8000_0000);
        send(csdm_pkg::KIND_READ, 6'd0, 6'd15, 32'd0);

        set_columns(5'd1);
        send(csdm_pkg::KIND_ACC, 6'd0, 6'd63, 32'h0001_0000);
        send(csdm_pkg::KIND_READ, 6'd0, 6'd1, 32'd0);
        set_columns(5'd0);
        send(csdm_pkg::KIND_ACC, 6'd0, 6'd63, 32'hFFFF_FFFF);     // no columns: no change
        send(csdm_pkg::KIND_READ, 6'd0, 6'd0, 32'd0);
        set_columns(5'd31);                                       // clamps to 16

        // Random blocks with columns changed between phases
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            for (int j = 0; j < 4; j++) begin
                random_block();
                if (j == 2) drain();   // sender waits for all results
            end
            case (ph % 4)
                0: set_columns(5'd16);
                1: set_columns(5'd1);
                2: set_columns(5'($urandom_range(2, 15)));
                default: set_columns(5'd16);
            endcase
        end
        calm = 0;

        while (sb.read_queue.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (sb.mismatches == 0 && sb.read_queue.size() == 0)
            $display("[coo_sparse_dense_matmul_core] OK");
        else
            $display("[coo_sparse_dense_matmul_core] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
